// ===== hdl/cvhp_pkg.sv =====
// Shared types, codes and constants for the homography predictor.
// No dependencies.
package cvhp_pkg;

  localparam int DIM = 3;
  localparam int ELEMENTS = 9;

  typedef enum logic [1:0] {
    ST_FIRST    = 2'd0,
    ST_PRED     = 2'd1,
    ST_SINGULAR = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LDA, S_LDB, S_MUL, S_ACC, S_FIN, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_ADJ, PH_DET, PH_INV, PH_T, PH_P
  } phase_t;

  typedef enum logic [1:0] {
    SRC_PREV, SRC_CUR, SRC_ADJ, SRC_T
  } src_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
    logic sub;
    logic clr;
  } mac_ctrl_t;

  // cofactor operand indexes: adj[k] = m[k][0]*m[k][1] - m[k][2]*m[k][3]
  function automatic logic [3:0] minor_idx(input logic [3:0] k, input logic [1:0] j);
    logic [15:0] row;
    begin
      unique case (k)
        4'd0: row = {4'd4, 4'd8, 4'd5, 4'd7};
        4'd1: row = {4'd2, 4'd7, 4'd1, 4'd8};
        4'd2: row = {4'd1, 4'd5, 4'd2, 4'd4};
        4'd3: row = {4'd5, 4'd6, 4'd3, 4'd8};
        4'd4: row = {4'd0, 4'd8, 4'd2, 4'd6};
        4'd5: row = {4'd2, 4'd3, 4'd0, 4'd5};
        4'd6: row = {4'd3, 4'd7, 4'd4, 4'd6};
        4'd7: row = {4'd1, 4'd6, 4'd0, 4'd7};
        4'd8: row = {4'd0, 4'd4, 4'd1, 4'd3};
        default: row = '0;
      endcase
      minor_idx = row[15 - 4 * j -: 4];
    end
  endfunction

endpackage

// ===== hdl/cvhp_mac.sv =====
// Shared multiply-accumulate unit: 32x32 multiplier, 64-bit saturating
// accumulator, truncating rescale and 32-bit saturation. Uses cvhp_pkg.
module cvhp_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cvhp_pkg::mac_ctrl_t         ctrl,
  input  logic signed [31:0]          opa,
  input  logic signed [31:0]          opb,
  output logic signed [31:0]          res,
  output logic                        res_sat,
  output logic signed [63-FRAC_BITS:0] scaled,
  output logic                        ovf
);
  import cvhp_pkg::*;

  localparam int DETW = 64 - FRAC_BITS;

  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [64:0] base;
  logic signed [64:0] addend;
  logic signed [64:0] sum;
  logic               add_ovf;
  logic [63:0]        mag;
  logic [63:0]        sh;
  logic signed [63:0] scaled64;

  always_comb begin
    base   = ctrl.first ? 65'sd0 : {acc[63], acc};
    addend = ctrl.sub ? -{prod[63], prod} : {prod[63], prod};
    sum    = base + addend;
    add_ovf = sum[64] != sum[63];
    if (add_ovf) begin
      acc_next = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_next = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= opa * opb;
    end
    if (ctrl.acc_en) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      ovf <= 1'b0;
    end else if (ctrl.acc_en && add_ovf) begin
      ovf <= 1'b1;
    end
  end

  always_comb begin
    mag      = acc[63] ? (~acc + 64'd1) : acc;
    sh       = mag >> FRAC_BITS;
    scaled64 = acc[63] ? -$signed(sh) : $signed(sh);
    scaled   = scaled64[DETW-1:0];
    if (scaled64 > 64'sd2147483647) begin
      res     = 32'sh7fffffff;
      res_sat = 1'b1;
    end else if (scaled64 < -64'sd2147483648) begin
      res     = 32'sh80000000;
      res_sat = 1'b1;
    end else begin
      res     = scaled64[31:0];
      res_sat = 1'b0;
    end
  end

endmodule

// ===== hdl/cvhp_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero, result saturated to 32 bits. Uses cvhp_pkg.
module cvhp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [31:0]           dividend,
  input  logic signed [63-FRAC_BITS:0] divisor,
  output logic                         done,
  output logic signed [31:0]           quot,
  output logic                         quot_sat
);
  import cvhp_pkg::*;

  localparam int DETW = 64 - FRAC_BITS;
  localparam int NW   = 32 + FRAC_BITS;
  localparam int RW   = DETW + 1;
  localparam int CW   = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num;
  logic [DETW-1:0] den;
  logic [RW-1:0] rem;
  logic          neg;
  logic [RW-1:0] shifted;
  logic          qbit;
  logic [31:0]   amag;
  logic [NW-1:0] lim;

  always_comb begin
    shifted = {rem[RW-2:0], num[NW-1]};
    qbit    = shifted >= {1'b0, den};
    amag    = dividend[31] ? (~dividend + 32'd1) : dividend;
    lim     = NW'(1) << 31;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == CW'(1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= {amag, {FRAC_BITS{1'b0}}};
      den <= divisor[DETW-1] ? (~divisor + DETW'(1)) : divisor;
      rem <= '0;
      cnt <= CW'(NW);
      neg <= dividend[31] ^ divisor[DETW-1];
    end else if (busy) begin
      rem <= qbit ? (shifted - {1'b0, den}) : shifted;
      num <= {num[NW-2:0], qbit};
      cnt <= cnt - CW'(1);
    end
  end

  always_comb begin
    if (neg) begin
      quot_sat = num > lim;
      quot     = quot_sat ? 32'sh80000000 : -$signed(num[31:0]);
    end else begin
      quot_sat = num >= lim;
      quot     = quot_sat ? 32'sh7fffffff : $signed(num[31:0]);
    end
  end

endmodule

// ===== hdl/constant_velocity_homography_predictor.sv =====
// One matrix at a time: h_stall is high outside idle, and a passthrough goes
// straight to output. The prediction uses one shared 32x32 multiply-accumulate
// (75 products) and one bit-serial divider (one division per inverse entry).
// Reset clears the previous-matrix flag; the first matrix after it passes through.
module constant_velocity_homography_predictor #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               h_valid,
  output logic               h_stall,
  input  logic signed [31:0] h0,
  input  logic signed [31:0] h1,
  input  logic signed [31:0] h2,
  input  logic signed [31:0] h3,
  input  logic signed [31:0] h4,
  input  logic signed [31:0] h5,
  input  logic signed [31:0] h6,
  input  logic signed [31:0] h7,
  input  logic signed [31:0] h8,
  input  logic               restart,
  output logic               p_valid,
  input  logic               p_stall,
  output logic signed [31:0] p0,
  output logic signed [31:0] p1,
  output logic signed [31:0] p2,
  output logic signed [31:0] p3,
  output logic signed [31:0] p4,
  output logic signed [31:0] p5,
  output logic signed [31:0] p6,
  output logic signed [31:0] p7,
  output logic signed [31:0] p8,
  output logic [1:0]         status
);
  import cvhp_pkg::*;

  localparam int DETW = 64 - FRAC_BITS;

  state_t  state, state_next;
  phase_t  phase;
  logic [1:0] r, c, term;
  logic [3:0] k, ia, ib, rd_idx;
  src_t    rd_src;
  logic signed [31:0] rd_data;
  logic    last_term, last_k;
  logic    have_prev;
  logic    sat;
  status_t st;

  logic signed [31:0] prevm [ELEMENTS];
  logic signed [31:0] cur   [ELEMENTS];
  logic signed [31:0] adj   [ELEMENTS];
  logic signed [31:0] tm    [ELEMENTS];
  logic signed [31:0] pm    [ELEMENTS];
  logic signed [31:0] hin   [ELEMENTS];

  logic signed [31:0] opa, opb;
  logic signed [DETW-1:0] det;

  mac_ctrl_t mac_ctrl;
  logic signed [31:0] mac_res;
  logic    mac_res_sat;
  logic signed [DETW-1:0] mac_scaled;
  logic    mac_ovf;
  logic    div_start, div_done, div_sat;
  logic signed [31:0] div_q;

  cvhp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst(rst), .ctrl(mac_ctrl), .opa(opa), .opb(opb),
    .res(mac_res), .res_sat(mac_res_sat), .scaled(mac_scaled), .ovf(mac_ovf)
  );

  cvhp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(opa), .divisor(det),
    .done(div_done), .quot(div_q), .quot_sat(div_sat)
  );

  assign hin = '{h0, h1, h2, h3, h4, h5, h6, h7, h8};

  always_comb begin
    k         = {2'b00, r} * 4'(DIM) + {2'b00, c};
    last_k    = r == 2'd2 && c == 2'd2;
    last_term = (phase == PH_ADJ) ? term == 2'd1 : term == 2'd2;
    ia = '0;
    ib = '0;
    rd_src = SRC_PREV;
    unique case (phase)
      PH_ADJ: begin
        ia = minor_idx(k, {term[0], 1'b0});
        ib = minor_idx(k, {term[0], 1'b1});
      end
      PH_DET: begin
        ia = {2'b00, term};
        ib = {2'b00, term} * 4'(DIM);
      end
      PH_INV: begin
        ia = k;
        ib = k;
      end
      PH_T, PH_P: begin
        ia = {2'b00, r} * 4'(DIM) + {2'b00, term};
        ib = {2'b00, term} * 4'(DIM) + {2'b00, c};
      end
      default: begin
        ia = '0;
        ib = '0;
      end
    endcase
    rd_idx = (state == S_LDB) ? ib : ia;
    unique case (phase)
      PH_ADJ:  rd_src = SRC_PREV;
      PH_DET:  rd_src = (state == S_LDB) ? SRC_ADJ : SRC_PREV;
      PH_INV:  rd_src = SRC_ADJ;
      PH_T:    rd_src = (state == S_LDB) ? SRC_ADJ : SRC_CUR;
      PH_P:    rd_src = (state == S_LDB) ? SRC_CUR : SRC_T;
      default: rd_src = SRC_PREV;
    endcase
    unique case (rd_src)
      SRC_PREV: rd_data = prevm[rd_idx];
      SRC_CUR:  rd_data = cur[rd_idx];
      SRC_ADJ:  rd_data = adj[rd_idx];
      SRC_T:    rd_data = tm[rd_idx];
      default:  rd_data = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (h_valid) state_next = (have_prev && !restart) ? S_LDA : S_OUT;
      S_LDA:      state_next = (phase == PH_INV) ? S_DIV_GO : S_LDB;
      S_LDB:      state_next = S_MUL;
      S_MUL:      state_next = S_ACC;
      S_ACC:      state_next = last_term ? S_FIN : S_LDA;
      S_FIN: begin
        priority if (phase == PH_DET && mac_scaled == '0) state_next = S_OUT;
        else if (phase == PH_P && last_k) state_next = S_OUT;
        else state_next = S_LDA;
      end
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_next = S_LDA;
      S_OUT:      if (!p_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    h_stall         = state != S_IDLE;
    p_valid         = state == S_OUT;
    div_start       = state == S_DIV_GO;
    mac_ctrl.mul_en = state == S_MUL;
    mac_ctrl.acc_en = state == S_ACC;
    mac_ctrl.first  = term == 2'd0;
    mac_ctrl.sub    = phase == PH_ADJ && term == 2'd1;
    mac_ctrl.clr    = state == S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && h_valid) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (h_valid) begin
          cur   <= hin;
          phase <= PH_ADJ;
          r     <= '0;
          c     <= '0;
          term  <= '0;
          sat   <= 1'b0;
          if (!have_prev || restart) begin
            pm    <= hin;
            prevm <= hin;
            st    <= ST_FIRST;
          end
        end
      end
      S_LDA: opa <= rd_data;
      S_LDB: opb <= rd_data;
      S_MUL: ;
      S_ACC: term <= last_term ? 2'd0 : term + 2'd1;
      S_FIN: begin
        c <= (c == 2'd2) ? 2'd0 : c + 2'd1;
        if (c == 2'd2) r <= last_k ? 2'd0 : r + 2'd1;
        unique case (phase)
          PH_ADJ: begin
            adj[k] <= mac_res;
            sat    <= sat | mac_res_sat;
            if (last_k) phase <= PH_DET;
          end
          PH_DET: begin
            r   <= '0;
            c   <= '0;
            det <= mac_scaled;
            if (mac_scaled == '0) begin
              pm    <= cur;
              prevm <= cur;
              st    <= ST_SINGULAR;
            end else begin
              phase <= PH_INV;
            end
          end
          PH_T: begin
            tm[k] <= mac_res;
            sat   <= sat | mac_res_sat;
            if (last_k) phase <= PH_P;
          end
          PH_P: begin
            pm[k] <= mac_res;
            if (last_k) begin
              prevm <= cur;
              st    <= (sat || mac_ovf || mac_res_sat) ? ST_SAT : ST_PRED;
            end else begin
              sat <= sat | mac_res_sat;
            end
          end
          default: ;
        endcase
      end
      S_DIV_GO: ;
      S_DIV_WAIT: begin
        if (div_done) begin
          adj[k] <= div_q;
          sat    <= sat | div_sat;
          c <= (c == 2'd2) ? 2'd0 : c + 2'd1;
          if (c == 2'd2) r <= last_k ? 2'd0 : r + 2'd1;
          if (last_k) phase <= PH_T;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  assign p0 = pm[0];
  assign p1 = pm[1];
  assign p2 = pm[2];
  assign p3 = pm[3];
  assign p4 = pm[4];
  assign p5 = pm[5];
  assign p6 = pm[6];
  assign p7 = pm[7];
  assign p8 = pm[8];
  assign status = st;

endmodule
